FILE: rtl/eqm_pkg.sv
package eqm_pkg;

    localparam int unsigned MAX_MARKERS_DEF = 16;
    localparam int unsigned FREQ_MIN_DEF    = 320;
    localparam int unsigned FREQ_MAX_DEF    = 320000;

    localparam int unsigned FREQ_W  = 24;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned TENS_W  = 17;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned COORD_W = 26;
    localparam int unsigned AMT_W   = 17;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic signed [GAIN_W-1:0] GAIN_LIMIT = GAIN_W'(10240);
    localparam int unsigned OUT_LIMIT = 16384;
    localparam int unsigned LN2_Q16   = 45426;
    localparam int unsigned EPS_LOG   = 7;
    localparam int unsigned EPS_LIN   = 1;
    localparam int unsigned UNITY_Q16 = 65536;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] IM_LINEAR = 2'd0;
    localparam logic [1:0] IM_SPLINE = 2'd1;
    localparam logic [1:0] IM_STEP   = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_AXIS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INTERP  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TENSION = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_COUNT   = 2'd3;

    typedef struct packed {
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic [FREQ_W-1:0]        freq;
        logic signed [GAIN_W-1:0] gain;
    } t_cmd;

    typedef struct packed {
        logic              axis;
        logic [1:0]        interp;
        logic [TENS_W-1:0] tension;
        logic [CNT_W-1:0]  count;
    } t_cfg;

    // ln(1+k/16) in q0.16
    function automatic logic [15:0] ln_tab(input logic [4:0] k);
        logic [15:0] v;
        unique case (k)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3973;
            5'd2:  v = 16'd7719;
            5'd3:  v = 16'd11262;
            5'd4:  v = 16'd14624;
            5'd5:  v = 16'd17822;
            5'd6:  v = 16'd20870;
            5'd7:  v = 16'd23783;
            5'd8:  v = 16'd26573;
            5'd9:  v = 16'd29248;
            5'd10: v = 16'd31818;
            5'd11: v = 16'd34292;
            5'd12: v = 16'd36675;
            5'd13: v = 16'd38975;
            5'd14: v = 16'd41196;
            5'd15: v = 16'd43345;
            5'd16: v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/eqm_front.sv
module eqm_front #(
    parameter int unsigned MAX_MARKERS = eqm_pkg::MAX_MARKERS_DEF,
    parameter int unsigned FREQ_MIN    = eqm_pkg::FREQ_MIN_DEF,
    parameter int unsigned FREQ_MAX    = eqm_pkg::FREQ_MAX_DEF
) (
    input  logic                              i_valid,
    input  logic                              i_full,
    input  logic                              i_operation,
    input  logic [eqm_pkg::SLOT_W-1:0]        i_marker_slot,
    input  logic [eqm_pkg::FREQ_W-1:0]        i_marker_freq,
    input  logic signed [eqm_pkg::GAIN_W-1:0] i_marker_gain,
    input  logic [eqm_pkg::FREQ_W-1:0]        i_query_freq,
    output logic                              o_stall,
    output logic                              o_push,
    output eqm_pkg::t_cmd                     o_cmd
);
    import eqm_pkg::*;

    logic [FREQ_W-1:0] raw_f;
    logic [FREQ_W-1:0] clamp_f;
    logic signed [GAIN_W-1:0] clamp_g;
    logic drop;

    always_comb begin
        raw_f = (i_operation == OP_QUERY) ? i_query_freq : i_marker_freq;
        if (raw_f < FREQ_W'(FREQ_MIN)) begin
            clamp_f = FREQ_W'(FREQ_MIN);
        end else if (raw_f > FREQ_W'(FREQ_MAX)) begin
            clamp_f = FREQ_W'(FREQ_MAX);
        end else begin
            clamp_f = raw_f;
        end
        if (i_marker_gain > GAIN_LIMIT) begin
            clamp_g = GAIN_LIMIT;
        end else if (i_marker_gain < -GAIN_LIMIT) begin
            clamp_g = -GAIN_LIMIT;
        end else begin
            clamp_g = i_marker_gain;
        end
        // writes beyond the table are dropped here
        drop = (i_operation == OP_WRITE) && (8'(i_marker_slot) >= 8'(MAX_MARKERS));
    end

    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full && !drop;
    assign o_cmd.op   = i_operation;
    assign o_cmd.slot = i_marker_slot;
    assign o_cmd.freq = clamp_f;
    assign o_cmd.gain = clamp_g;

endmodule

FILE: rtl/eqm_queue.sv
module eqm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  eqm_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_avail,
    output eqm_pkg::t_cmd o_head
);
    import eqm_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> (r_cnt == NW'(QUEUE_DEPTH)) || $past(i_pop))
        else $error("queue overflow");
`endif

endmodule

FILE: rtl/eqm_back.sv
module eqm_back #(
    parameter int unsigned MAX_MARKERS = eqm_pkg::MAX_MARKERS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  eqm_pkg::t_cfg                      i_cfg,
    input  logic                               i_q_avail,
    input  eqm_pkg::t_cmd                      i_q_head,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [eqm_pkg::GAIN_W-1:0]  o_response_gain
);
    import eqm_pkg::*;

    localparam int unsigned AW    = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int unsigned CW    = $clog2(MAX_MARKERS + 1);
    localparam int unsigned KEY_W = FREQ_W + AW;
    localparam int unsigned MA_W  = 20;
    localparam int unsigned MB_W  = 34;
    localparam int unsigned P_W   = MA_W + MB_W;
    localparam int unsigned ACC_W = 56;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POS  = 6'b000010,
        S_SCAN = 6'b000100,
        S_DIV  = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    logic [FREQ_W-1:0]        mem_f [MAX_MARKERS];
    logic signed [GAIN_W-1:0] mem_g [MAX_MARKERS];

    t_state r_state;
    logic [CW-1:0] n_cnt;
    logic [FREQ_W-1:0] r_qf;
    logic signed [COORD_W-1:0] r_pos;
    logic r_pass;
    logic [CW-1:0] r_addr;
    logic r_issue;
    logic r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [FREQ_W-1:0] r_rd_f;
    logic signed [GAIN_W-1:0] r_rd_g;
    logic r_b_vld;
    logic signed [COORD_W-1:0] r_b_c;
    logic [FREQ_W-1:0] r_b_f;
    logic signed [GAIN_W-1:0] r_b_g;
    logic [AW-1:0] r_b_idx;

    logic r_have_fst, r_have_r, r_have_l, r_have_p, r_have_n;
    logic [KEY_W-1:0] r_fst_key, r_lst_key, r_r_key, r_l_key, r_p_key, r_n_key;
    logic signed [COORD_W-1:0] r_fst_c, r_lst_c, r_r_c, r_l_c;
    logic signed [GAIN_W-1:0] r_fst_g, r_lst_g, r_r_g, r_l_g, r_p_g, r_n_g;

    logic [COORD_W:0] r_rem;
    logic [COORD_W-1:0] r_den;
    logic [AMT_W-1:0] r_amt;
    logic [4:0] r_dcnt;

    logic [3:0] r_mstep;
    logic signed [P_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [AMT_W-1:0] r_a2, r_a3;
    logic signed [MB_W-1:0] r_m0, r_m1;

    logic signed [GAIN_W-1:0] r_res;
    logic r_out_vld;
    logic signed [GAIN_W-1:0] r_out_gain;

    logic [FREQ_W-1:0] coord_in;
    logic [4:0] lg_p;
    logic [FREQ_W-1:0] lg_m;
    logic [15:0] lg_lo, lg_hi;
    logic [34:0] lg_prod;
    logic [COORD_W-1:0] lg_sum;
    logic signed [COORD_W-1:0] coord_val;

    logic [KEY_W-1:0] b_key;
    logic pass_end;
    logic signed [COORD_W-1:0] den_raw;
    logic [COORD_W-1:0] den_eff;
    logic [COORD_W:0] div_t;
    logic div_bit;

    logic signed [MA_W-1:0] a_s, a2_s, a3_s, h00, h10, h01, h11;
    logic signed [GAIN_W-1:0] gp, gn;
    logic [AMT_W-1:0] scale;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;
    logic signed [ACC_W-1:0] acc_rnd, acc_sh;
    logic signed [P_W-1:0] lin_rnd, lin_sh;
    logic signed [GAIN_W-1:0] spl_res;
    logic out_free;
    logic spline;

    assign n_cnt = (8'(i_cfg.count) > 8'(MAX_MARKERS)) ? CW'(MAX_MARKERS) : CW'(i_cfg.count);
    assign o_q_pop = (r_state == S_IDLE) && i_q_avail;
    assign out_free = !r_out_vld || !i_out_stall;
    assign spline = (i_cfg.interp == IM_SPLINE);

    // coordinate unit: log or linear axis
    always_comb begin
        coord_in = (r_state == S_POS) ? r_qf : r_rd_f;
        lg_p = '0;
        for (int i = 1; i < FREQ_W; i++) begin
            if (coord_in[i]) begin
                lg_p = 5'(i);
            end
        end
        lg_m    = coord_in << (5'(FREQ_W - 1) - lg_p);
        lg_lo   = ln_tab({1'b0, lg_m[22:19]});
        lg_hi   = ln_tab({1'b0, lg_m[22:19]} + 5'd1);
        lg_prod = 35'(lg_hi - lg_lo) * 35'(lg_m[18:0]);
        lg_sum  = COORD_W'(lg_p) * COORD_W'(LN2_Q16) - COORD_W'(4 * LN2_Q16)
                  + COORD_W'(lg_lo) + COORD_W'(lg_prod[34:19]);
        coord_val = i_cfg.axis ? $signed(COORD_W'(coord_in)) : $signed(lg_sum);
    end

    always_comb begin
        b_key    = {r_b_f, r_b_idx};
        pass_end = (r_state == S_SCAN) && !r_issue && !r_rd_vld && !r_b_vld;
        den_raw  = r_r_c - r_l_c;
        if (i_cfg.axis) begin
            den_eff = (den_raw < $signed(COORD_W'(EPS_LIN))) ? COORD_W'(EPS_LIN)
                                                              : COORD_W'(den_raw);
        end else begin
            den_eff = (den_raw < $signed(COORD_W'(EPS_LOG))) ? COORD_W'(EPS_LOG)
                                                              : COORD_W'(den_raw);
        end
        div_t   = (r_dcnt == 5'd0) ? r_rem : {r_rem[COORD_W-1:0], 1'b0};
        div_bit = (div_t >= {1'b0, r_den});
    end

    // hermite bases and shared multiplier operands
    always_comb begin
        a_s  = $signed(MA_W'(r_amt));
        a2_s = $signed(MA_W'(r_a2));
        a3_s = $signed(MA_W'(r_a3));
        h00  = MA_W'(2) * a3_s - MA_W'(3) * a2_s + $signed(MA_W'(UNITY_Q16));
        h10  = a3_s - MA_W'(2) * a2_s + a_s;
        h01  = MA_W'(3) * a2_s - MA_W'(2) * a3_s;
        h11  = a3_s - a2_s;
        gp   = r_have_p ? r_p_g : r_l_g;
        gn   = r_have_n ? r_n_g : r_r_g;
        scale = (i_cfg.tension > TENS_W'(UNITY_Q16)) ? '0
                                                    : AMT_W'(UNITY_Q16 - 32'(i_cfg.tension));
        mul_a = a_s;
        mul_b = $signed(MB_W'(r_amt));
        if (!spline) begin
            mul_b = MB_W'(r_r_g) - MB_W'(r_l_g);
        end else begin
            case (r_mstep)
                4'd1: mul_a = $signed(MA_W'(r_prod[32:16]));
                4'd2: begin
                    mul_a = MA_W'(r_r_g) - MA_W'(gp);
                    mul_b = $signed(MB_W'(scale));
                end
                4'd3: begin
                    mul_a = MA_W'(gn) - MA_W'(r_l_g);
                    mul_b = $signed(MB_W'(scale));
                end
                4'd4: begin
                    mul_a = h00;
                    mul_b = MB_W'(r_l_g) <<< 17;
                end
                4'd5: begin
                    mul_a = h10;
                    mul_b = r_m0;
                end
                4'd6: begin
                    mul_a = h01;
                    mul_b = MB_W'(r_r_g) <<< 17;
                end
                4'd7: begin
                    mul_a = h11;
                    mul_b = r_m1;
                end
                default: ;
            endcase
        end
        mul_p   = mul_a * mul_b;
        acc_rnd = r_acc + $signed(ACC_W'(64'h1_0000_0000));
        acc_sh  = acc_rnd >>> 33;
        if (acc_sh > $signed(ACC_W'(OUT_LIMIT))) begin
            spl_res = GAIN_W'(OUT_LIMIT);
        end else if (acc_sh < -$signed(ACC_W'(OUT_LIMIT))) begin
            spl_res = -GAIN_W'(OUT_LIMIT);
        end else begin
            spl_res = GAIN_W'(acc_sh);
        end
        lin_rnd = r_prod + $signed(P_W'(32768));
        lin_sh  = lin_rnd >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_head.op == OP_WRITE)) begin
            mem_f[AW'(i_q_head.slot)] <= i_q_head.freq;
            mem_g[AW'(i_q_head.slot)] <= i_q_head.gain;
        end
        r_rd_f <= mem_f[r_addr[AW-1:0]];
        r_rd_g <= mem_g[r_addr[AW-1:0]];
    end

    // scan pipeline and datapath
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[AW-1:0];
        r_b_c    <= coord_val;
        r_b_f    <= r_rd_f;
        r_b_g    <= r_rd_g;
        r_b_idx  <= r_rd_idx;
        r_prod   <= mul_p;
        if (o_q_pop) begin
            r_qf <= i_q_head.freq;
        end
        if (r_state == S_POS) begin
            r_pos <= coord_val;
        end
        if (r_b_vld && !r_pass) begin
            if (!r_have_fst || b_key < r_fst_key) begin
                r_fst_key <= b_key;
                r_fst_c   <= r_b_c;
                r_fst_g   <= r_b_g;
            end
            if (!r_have_fst || b_key > r_lst_key) begin
                r_lst_key <= b_key;
                r_lst_c   <= r_b_c;
                r_lst_g   <= r_b_g;
            end
            if (r_b_c >= r_pos && (!r_have_r || b_key < r_r_key)) begin
                r_r_key <= b_key;
                r_r_c   <= r_b_c;
                r_r_g   <= r_b_g;
            end
        end
        if (r_b_vld && r_pass) begin
            if (b_key < r_r_key) begin
                if (!r_have_l || b_key > r_l_key) begin
                    r_p_key <= r_l_key;
                    r_p_g   <= r_l_g;
                    r_l_key <= b_key;
                    r_l_c   <= r_b_c;
                    r_l_g   <= r_b_g;
                end else if (!r_have_p || b_key > r_p_key) begin
                    r_p_key <= b_key;
                    r_p_g   <= r_b_g;
                end
            end else if (b_key > r_r_key && (!r_have_n || b_key < r_n_key)) begin
                r_n_key <= b_key;
                r_n_g   <= r_b_g;
            end
        end
        if (pass_end && r_pass) begin
            r_rem <= (COORD_W + 1)'(r_pos - r_l_c);
            r_den <= den_eff;
        end
        if (r_state == S_DIV) begin
            r_rem <= div_bit ? div_t - {1'b0, r_den} : div_t;
            r_amt <= {r_amt[AMT_W-2:0], div_bit};
        end
        if (r_state == S_MUL) begin
            unique case (r_mstep)
                4'd1: r_a2 <= r_prod[32:16];
                4'd2: r_a3 <= r_prod[32:16];
                4'd3: r_m0 <= r_prod[MB_W-1:0];
                4'd4: r_m1 <= r_prod[MB_W-1:0];
                4'd5: r_acc <= ACC_W'(r_prod);
                4'd6, 4'd7, 4'd8: r_acc <= r_acc + ACC_W'(r_prod);
                default: ;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out_gain <= r_res;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass     <= 1'b0;
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_b_vld    <= 1'b0;
            r_have_fst <= 1'b0;
            r_have_r   <= 1'b0;
            r_have_l   <= 1'b0;
            r_have_p   <= 1'b0;
            r_have_n   <= 1'b0;
            r_dcnt     <= '0;
            r_mstep    <= '0;
            r_res      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            r_b_vld  <= r_rd_vld;
            if (r_issue) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr + 1'b1 == n_cnt) begin
                    r_issue <= 1'b0;
                end
            end
            if (r_b_vld && !r_pass) begin
                r_have_fst <= 1'b1;
                if (r_b_c >= r_pos) begin
                    r_have_r <= 1'b1;
                end
            end
            if (r_b_vld && r_pass) begin
                if (b_key < r_r_key) begin
                    if (!r_have_l || b_key > r_l_key) begin
                        r_have_p <= r_have_l;
                        r_have_l <= 1'b1;
                    end else begin
                        r_have_p <= 1'b1;
                    end
                end else if (b_key > r_r_key) begin
                    r_have_n <= 1'b1;
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_head.op == OP_QUERY) begin
                        if (n_cnt == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_POS;
                        end
                    end
                end
                S_POS: begin
                    r_have_fst <= 1'b0;
                    r_have_r   <= 1'b0;
                    r_pass     <= 1'b0;
                    r_addr     <= '0;
                    r_issue    <= 1'b1;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (pass_end && !r_pass) begin
                        if (r_pos <= r_fst_c) begin
                            r_res   <= r_fst_g;
                            r_state <= S_DONE;
                        end else if (r_pos >= r_lst_c) begin
                            r_res   <= r_lst_g;
                            r_state <= S_DONE;
                        end else begin
                            r_pass   <= 1'b1;
                            r_addr   <= '0;
                            r_issue  <= 1'b1;
                            r_have_l <= 1'b0;
                            r_have_p <= 1'b0;
                            r_have_n <= 1'b0;
                        end
                    end else if (pass_end) begin
                        if (i_cfg.interp == IM_STEP) begin
                            r_res   <= r_l_g;
                            r_state <= S_DONE;
                        end else begin
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'(AMT_W - 1)) begin
                        r_mstep <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (!spline && r_mstep == 4'd1) begin
                        r_res   <= r_l_g + GAIN_W'(lin_sh);
                        r_state <= S_DONE;
                    end else if (spline && r_mstep == 4'd9) begin
                        r_res   <= spl_res;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_response_gain = r_out_gain;

`ifndef SYNTHESIS
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_have_l && r_have_r && r_l_key < r_r_key))
        else $error("no bracketing pair before divide");
    a_amount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_amt <= AMT_W'(UNITY_Q16)))
        else $error("amount above unity");
    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> $past(r_state == S_SCAN, 2))
        else $error("table read outside a scan");
`endif

endmodule

FILE: rtl/eq_marker_curve_interpolator.sv
// channel   dir  handshake                   payload
// request   in   i_in_valid / o_in_stall     i_operation, i_marker_slot, i_marker_freq,
//                                            i_marker_gain, i_query_freq
// result    out  o_out_valid / i_out_stall   o_response_gain
// config    in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// a marker write is stored in the cycle after it is accepted when the back end is idle
// a query, once popped, makes two passes over the single-port marker table, then runs a
// 17-step divider and 2 (linear) or 10 (spline) multiplier steps; step mode and
// out-of-range end sooner
// synchronous active-low reset clears control and config, not the marker table
// requests stall only when the two-entry queue is full; results wait in an output register
module eq_marker_curve_interpolator #(
    parameter int unsigned MAX_MARKERS = eqm_pkg::MAX_MARKERS_DEF,
    parameter int unsigned FREQ_MIN    = eqm_pkg::FREQ_MIN_DEF,
    parameter int unsigned FREQ_MAX    = eqm_pkg::FREQ_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [eqm_pkg::SLOT_W-1:0]        i_marker_slot,
    input  logic [eqm_pkg::FREQ_W-1:0]        i_marker_freq,
    input  logic signed [eqm_pkg::GAIN_W-1:0] i_marker_gain,
    input  logic [eqm_pkg::FREQ_W-1:0]        i_query_freq,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [eqm_pkg::GAIN_W-1:0] o_response_gain,
    input  logic                              i_cfg_we,
    input  logic [eqm_pkg::CIDX_W-1:0]        i_cfg_idx,
    input  logic [eqm_pkg::TENS_W-1:0]        i_cfg_data
);
    import eqm_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic avail;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AXIS:    r_cfg.axis    <= i_cfg_data[0];
                CFG_INTERP:  r_cfg.interp  <= i_cfg_data[1:0];
                CFG_TENSION: r_cfg.tension <= i_cfg_data;
                CFG_COUNT:   r_cfg.count   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    eqm_front #(
        .MAX_MARKERS (MAX_MARKERS),
        .FREQ_MIN    (FREQ_MIN),
        .FREQ_MAX    (FREQ_MAX)
    ) u_front (
        .i_valid       (i_in_valid),
        .i_full        (full),
        .i_operation   (i_operation),
        .i_marker_slot (i_marker_slot),
        .i_marker_freq (i_marker_freq),
        .i_marker_gain (i_marker_gain),
        .i_query_freq  (i_query_freq),
        .o_stall       (o_in_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    eqm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_head  (head_cmd)
    );

    eqm_back #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_avail       (avail),
        .i_q_head        (head_cmd),
        .o_q_pop         (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_response_gain (o_response_gain)
    );

endmodule

FILE: tb/tb_eq_marker_curve_interpolator.sv
`timescale 1ns / 100ps

module tb_eq_marker_curve_interpolator;
    import eqm_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int LO_FREQ    = 320;
    localparam int HI_FREQ    = 320000;
    localparam int SETTLE     = 120;

    // ln(1+k/16) in q0.16
    localparam int LN_STEPS [17] = '{0, 3973, 7719, 11262, 14624, 17822, 20870, 23783,
        26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

    class eq_curve_scoreboard;
        logic                     axis_lin;
        logic [1:0]               interp;
        logic [TENS_W-1:0]        tens;
        logic [CNT_W-1:0]         count;
        logic [FREQ_W-1:0]        freqs [TABLE_SIZE];
        logic signed [GAIN_W-1:0] gains [TABLE_SIZE];
        logic signed [GAIN_W-1:0] pending_gains [$];
        int                       errors;

        function new();
            axis_lin = 0;
            interp   = IM_LINEAR;
            tens     = '0;
            count    = '0;
            errors   = 0;
        endfunction

        function longint clamp_freq(longint f);
            if (f < LO_FREQ) return LO_FREQ;
            if (f > HI_FREQ) return HI_FREQ;
            return f;
        endfunction

        function longint axis_coord(longint f);
            int     msb;
            longint m, frac, k, r;
            if (axis_lin) return f;
            msb = 0;
            while (msb < 23 && (f >> (msb + 1)) != 0) msb++;
            m    = (f << (23 - msb)) & 24'hFFFFFF;
            frac = m & 23'h7FFFFF;
            k    = frac >> 19;
            r    = frac & 19'h7FFFF;
            return longint'(msb - 4) * LN2_Q16 + LN_STEPS[k]
                + (((LN_STEPS[k + 1] - LN_STEPS[k]) * r) >>> 19);
        endfunction

        function longint curve_gain(longint qf);
            longint fs [TABLE_SIZE];
            longint gs [TABLE_SIZE];
            longint cs [TABLE_SIZE];
            longint pos, den, a, gl, gr, gp, gn, scale, a2, a3, sum, res;
            int     n, j, rt;
            n = (count > TABLE_SIZE) ? TABLE_SIZE : count;
            if (n == 0) return 0;
            for (int i = 0; i < n; i++) begin
                j = i;
                while (j > 0 && fs[j - 1] > clamp_freq(freqs[i])) begin
                    fs[j] = fs[j - 1];
                    gs[j] = gs[j - 1];
                    j--;
                end
                fs[j] = clamp_freq(freqs[i]);
                gs[j] = gains[i];
            end
            for (int i = 0; i < n; i++) cs[i] = axis_coord(fs[i]);
            pos = axis_coord(clamp_freq(qf));
            if (pos <= cs[0]) return gs[0];
            if (pos >= cs[n - 1]) return gs[n - 1];
            rt = 1;
            while (rt < n && pos > cs[rt]) rt++;
            den = cs[rt] - cs[rt - 1];
            if (axis_lin) begin
                if (den < EPS_LIN) den = EPS_LIN;
            end else if (den < EPS_LOG) begin
                den = EPS_LOG;
            end
            a  = ((pos - cs[rt - 1]) << 16) / den;
            gl = gs[rt - 1];
            gr = gs[rt];
            if (interp == IM_STEP) return gl;
            if (interp != IM_SPLINE) return gl + (((gr - gl) * a + 32768) >>> 16);
            gp    = gs[(rt >= 2) ? rt - 2 : rt - 1];
            gn    = gs[(rt + 1 < n) ? rt + 1 : rt];
            scale = UNITY_Q16 - ((tens > UNITY_Q16) ? UNITY_Q16 : tens);
            a2    = (a * a) >>> 16;
            a3    = (a2 * a) >>> 16;
            sum   = (2 * a3 - 3 * a2 + 65536) * gl * 131072
                  + (a3 - 2 * a2 + a) * (gr - gp) * scale
                  + (-2 * a3 + 3 * a2) * gr * 131072
                  + (a3 - a2) * (gn - gl) * scale;
            res   = (sum + (longint'(1) << 32)) >>> 33;
            if (res > longint'(OUT_LIMIT)) res = longint'(OUT_LIMIT);
            if (res < -longint'(OUT_LIMIT)) res = -longint'(OUT_LIMIT);
            return res;
        endfunction

        function void note_request(logic op, logic [SLOT_W-1:0] slot, logic [FREQ_W-1:0] f,
                                   logic signed [GAIN_W-1:0] g, logic [FREQ_W-1:0] qf);
            longint gv;
            if (op == OP_QUERY) begin
                pending_gains.push_back(GAIN_W'(curve_gain(qf)));
            end else begin
                gv = g;
                if (gv > 10240) gv = 10240;
                if (gv < -10240) gv = -10240;
                freqs[slot] = FREQ_W'(clamp_freq(f));
                gains[slot] = GAIN_W'(gv);
            end
        endfunction

        function void check_response(logic signed [GAIN_W-1:0] got);
            logic signed [GAIN_W-1:0] want;
            if (pending_gains.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_gains.pop_front();
            if (got !== want) begin
                $display("%0t: response_gain mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_operation;
    logic [SLOT_W-1:0]        i_marker_slot;
    logic [FREQ_W-1:0]        i_marker_freq;
    logic signed [GAIN_W-1:0] i_marker_gain;
    logic [FREQ_W-1:0]        i_query_freq;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [GAIN_W-1:0] o_response_gain;
    logic                     i_cfg_we;
    logic [CIDX_W-1:0]        i_cfg_idx;
    logic [TENS_W-1:0]        i_cfg_data;

    eq_curve_scoreboard curve_sb;
    int  send_idle_pct;
    int  stall_pct;
    logic pressure_go;
    logic pressure_done;
    int  hold_left;

    eq_marker_curve_interpolator i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // long hold-off on the result side, once
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_go && !pressure_done) begin
            hold_left     <= 400;
            pressure_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) curve_sb.check_response(o_response_gain);
    end

    task automatic send_request(logic op, logic [SLOT_W-1:0] slot, logic [FREQ_W-1:0] f,
                                logic signed [GAIN_W-1:0] g, logic [FREQ_W-1:0] qf);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_operation   <= op;
        i_marker_slot <= slot;
        i_marker_freq <= f;
        i_marker_gain <= g;
        i_query_freq  <= qf;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        curve_sb.note_request(op, slot, f, g, qf);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (curve_sb.pending_gains.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(logic ax, logic [1:0] im, logic [TENS_W-1:0] t,
                                logic [CNT_W-1:0] c);
        logic [TENS_W-1:0] vals [4];
        logic [CIDX_W-1:0] idxs [4];
        vals = '{TENS_W'(ax), TENS_W'(im), t, TENS_W'(c)};
        idxs = '{CFG_AXIS, CFG_INTERP, CFG_TENSION, CFG_COUNT};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        curve_sb.axis_lin = ax;
        curve_sb.interp   = im;
        curve_sb.tens     = t;
        curve_sb.count    = c;
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            0: return FREQ_W'($urandom);
            1: return FREQ_W'($urandom_range(400));
            2: return FREQ_W'($urandom_range(330000, 315000));
            default: return FREQ_W'((LO_FREQ << $urandom_range(9)) + $urandom_range(255));
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        if ($urandom_range(4) == 0) return GAIN_W'($urandom);
        return GAIN_W'(int'($urandom_range(20480)) - 10240);
    endfunction

    task automatic random_requests(int num);
        for (int k = 0; k < num; k++) begin
            if ($urandom_range(9) < 6)
                send_request(OP_QUERY, SLOT_W'($urandom), pick_freq(), pick_gain(),
                             pick_freq());
            else
                send_request(OP_WRITE, SLOT_W'($urandom), pick_freq(), pick_gain(),
                             pick_freq());
        end
    endtask

    initial begin
        logic              ax;
        logic [1:0]        im;
        logic [TENS_W-1:0] t;
        logic [CNT_W-1:0]  c;
        curve_sb      = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        pressure_go   = 1'b0;
        pressure_done = 1'b0;
        hold_left     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_operation   = OP_WRITE;
        i_marker_slot = '0;
        i_marker_freq = '0;
        i_marker_gain = '0;
        i_query_freq  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_AXIS;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        send_request(OP_QUERY, 0, 0, 0, 24'd0);
        send_request(OP_QUERY, 0, 0, 0, 24'hFFFFFF);
        // fill every slot, extremes and a tie
        for (int s = 0; s < TABLE_SIZE; s++) begin
            case (s)
                0: send_request(OP_WRITE, SLOT_W'(s), 24'd0, 16'sh8000, 0);
                1: send_request(OP_WRITE, SLOT_W'(s), 24'hFFFFFF, 16'sh7FFF, 0);
                2: send_request(OP_WRITE, SLOT_W'(s), 24'd4000, 16'sd10240, 0);
                3: send_request(OP_WRITE, SLOT_W'(s), 24'd4000, -16'sd10240, 0);
                default: send_request(OP_WRITE, SLOT_W'(s), FREQ_W'(LO_FREQ + s * 19000),
                                      GAIN_W'((s % 3 - 1) * 2500), 0);
            endcase
        end
        drain();
        write_config(1'b0, IM_LINEAR, 0, CNT_W'(TABLE_SIZE));
        send_request(OP_QUERY, 0, 0, 0, 24'd0);
        send_request(OP_QUERY, 0, 0, 0, 24'hFFFFFF);
        send_request(OP_QUERY, 0, 0, 0, 24'd4000);
        send_request(OP_QUERY, 0, 0, 0, 24'd50000);
        drain();
        write_config(1'b1, IM_SPLINE, 0, CNT_W'(TABLE_SIZE));
        send_request(OP_QUERY, 0, 0, 0, 24'd30000);
        send_request(OP_QUERY, 0, 0, 0, 24'd150007);
        drain();
        write_config(1'b0, IM_STEP, 0, CNT_W'(TABLE_SIZE));
        send_request(OP_QUERY, 0, 0, 0, 24'd90000);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            case (ph)
                0: begin ax = 0; im = IM_SPLINE; t = 0;          c = 16; end
                1: begin ax = 1; im = IM_SPLINE; t = 17'd65536;  c = 31; end
                2: begin ax = 0; im = 2'd3;      t = 17'h1FFFF;  c = 2;  end
                3: begin ax = 1; im = IM_STEP;   t = 0;          c = 1;  end
                4: begin ax = 0; im = IM_LINEAR; t = 0;          c = 0;  end
                5: begin ax = 1; im = IM_LINEAR; t = 0;          c = 20; end
                default: begin
                    ax = 1'($urandom);
                    im = 2'($urandom_range(3));
                    t  = TENS_W'($urandom);
                    c  = CNT_W'($urandom_range(31, 2));
                end
            endcase
            write_config(ax, im, t, c);
            if (ph == 8) pressure_go <= 1'b1;
            random_requests(50);
            drain();
        end

        if (curve_sb.errors == 0 && curve_sb.pending_gains.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/eqm_pkg.sv
rtl/eqm_front.sv
rtl/eqm_queue.sv
rtl/eqm_back.sv
rtl/eq_marker_curve_interpolator.sv
tb/tb_eq_marker_curve_interpolator.sv
